// ===== rtl/core/farp_pkg.sv =====
// Package for the archive record parser: record kinds, attribute tag codes,
// body classes, the result word type and the tag lookup function.
// Depends on nothing; used by file_archive_record_parser.
package farp_pkg;

  localparam int ByteW  = 8;
  localparam int ValueW = 32;
  localparam int SizeW  = 24;
  localparam int KindW  = 4;
  localparam int LenW   = 3;

  // Record kinds.
  localparam logic [KindW-1:0] KIND_NAME_BYTE = 4'd0;
  localparam logic [KindW-1:0] KIND_NAME_END  = 4'd1;
  localparam logic [KindW-1:0] KIND_TYPE      = 4'd2;
  localparam logic [KindW-1:0] KIND_MTIME     = 4'd3;
  localparam logic [KindW-1:0] KIND_GID       = 4'd4;
  localparam logic [KindW-1:0] KIND_UID       = 4'd5;
  localparam logic [KindW-1:0] KIND_INODE     = 4'd6;
  localparam logic [KindW-1:0] KIND_MODE      = 4'd7;
  localparam logic [KindW-1:0] KIND_SIZE      = 4'd8;
  localparam logic [KindW-1:0] KIND_ATTR_END  = 4'd9;
  localparam logic [KindW-1:0] KIND_LINK_BYTE = 4'd10;
  localparam logic [KindW-1:0] KIND_DATA_BYTE = 4'd11;
  localparam logic [KindW-1:0] KIND_ARCH_END  = 4'd12;
  localparam logic [KindW-1:0] KIND_BAD_TAG   = 4'd13;
  localparam logic [KindW-1:0] KIND_NONE      = 4'd0;

  // Attribute tags.
  localparam logic [ByteW-1:0] TAG_END       = 8'h00;
  localparam logic [ByteW-1:0] TAG_TYPE_LO   = 8'h01;
  localparam logic [ByteW-1:0] TAG_TYPE_LINK = 8'h03;
  localparam logic [ByteW-1:0] TAG_TYPE_HI   = 8'h05;
  localparam logic [ByteW-1:0] TAG_MTIME     = 8'h10;
  localparam logic [ByteW-1:0] TAG_GID_S     = 8'h67;
  localparam logic [ByteW-1:0] TAG_GID_L     = 8'h47;
  localparam logic [ByteW-1:0] TAG_UID_S     = 8'h75;
  localparam logic [ByteW-1:0] TAG_UID_L     = 8'h55;
  localparam logic [ByteW-1:0] TAG_INODE_S   = 8'h69;
  localparam logic [ByteW-1:0] TAG_INODE_L   = 8'h49;
  localparam logic [ByteW-1:0] TAG_MODE_S    = 8'h6D;
  localparam logic [ByteW-1:0] TAG_MODE_L    = 8'h4D;
  localparam logic [ByteW-1:0] TAG_SIZE_S    = 8'h73;
  localparam logic [ByteW-1:0] TAG_SIZE_L    = 8'h53;

  // Body classes.
  localparam logic [1:0] BODY_DATA = 2'd0;
  localparam logic [1:0] BODY_NONE = 2'd1;
  localparam logic [1:0] BODY_LINK = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    logic              done;
    logic              ignored;
  } res_t;

  typedef struct packed {
    logic [KindW-1:0] kind;  // KIND_NONE when the tag is unknown
    logic [LenW-1:0]  len;
  } tag_info_t;

  function automatic tag_info_t tag_info(input logic [ByteW-1:0] tag);
    tag_info_t t;
    t.kind = KIND_NONE;
    t.len  = 3'd0;
    unique case (tag)
      TAG_MTIME:   begin t.kind = KIND_MTIME; t.len = 3'd4; end
      TAG_GID_S:   begin t.kind = KIND_GID;   t.len = 3'd1; end
      TAG_GID_L:   begin t.kind = KIND_GID;   t.len = 3'd4; end
      TAG_UID_S:   begin t.kind = KIND_UID;   t.len = 3'd1; end
      TAG_UID_L:   begin t.kind = KIND_UID;   t.len = 3'd4; end
      TAG_INODE_S: begin t.kind = KIND_INODE; t.len = 3'd1; end
      TAG_INODE_L: begin t.kind = KIND_INODE; t.len = 3'd2; end
      TAG_MODE_S:  begin t.kind = KIND_MODE;  t.len = 3'd2; end
      TAG_MODE_L:  begin t.kind = KIND_MODE;  t.len = 3'd4; end
      TAG_SIZE_S:  begin t.kind = KIND_SIZE;  t.len = 3'd1; end
      TAG_SIZE_L:  begin t.kind = KIND_SIZE;  t.len = 3'd3; end
      default:     begin t.kind = KIND_NONE;  t.len = 3'd0; end
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/file_archive_record_parser.sv =====
// Archive record parser top level: byte-wide parse state machine with a
// two-word result buffer (output register plus skid register).
// Depends on farp_pkg.
//
// Usage: the archive image enters one byte per word on the in_ channel
// (in_valid, in_stall, in_byte). Each file is a NUL-ended name, tagged
// attributes ended by a zero byte, and a body. Name bytes, the name end,
// finished attributes, the attribute-list end, body bytes, the archive end
// and an unknown tag each produce one record word on the out_ channel. Other
// tag bytes and the leading bytes of a multi-byte field produce nothing.
// Throughput is one byte per cycle while in_stall is low; the parse state
// machine updates when a byte is accepted, and its record is registered in
// the output register, or parked in the skid register while the output
// register is stalled; in_stall rises only while that skid register
// is full, so the receiver may stall for any length of time and nothing
// is lost. After an archive-end record or an unknown-tag record the block
// swallows all further bytes until reset.
// cfg_wr_en/cfg_wr_data set the byte order of multi-byte fields (0 little,
// 1 big endian); write it only while the block is idle.
// Reset (rst_n low, synchronous) empties the result buffer, returns the
// parser to the start of a file and selects little-endian fields.
module file_archive_record_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [farp_pkg::ByteW-1:0]  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [farp_pkg::KindW-1:0]  out_record_kind,
  output logic [farp_pkg::ValueW-1:0] out_record_value,
  output logic                        out_file_done,
  output logic                        out_size_ignored,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data
);

  localparam logic [2:0] PH_FILE_START = 3'd0;
  localparam logic [2:0] PH_NAME       = 3'd1;
  localparam logic [2:0] PH_TAG        = 3'd2;
  localparam logic [2:0] PH_FIELD      = 3'd3;
  localparam logic [2:0] PH_BODY       = 3'd4;
  localparam logic [2:0] PH_HALTED     = 3'd5;
  localparam logic [2:0] PH_ENDED      = 3'd6;

  // Parser state.
  logic [2:0]                        phase_r, phase_nxt;
  logic [farp_pkg::ByteW-1:0]        tag_r, tag_nxt;
  logic [farp_pkg::LenW-1:0]         left_r, left_nxt;
  logic [farp_pkg::ValueW-1:0]       acc_r, acc_nxt;
  logic [1:0]                        body_class_r, body_class_nxt;
  logic [farp_pkg::SizeW-1:0]        size_r, size_nxt;
  logic [farp_pkg::SizeW-1:0]        body_left_r, body_left_nxt;
  logic                              big_endian_r;

  // Result buffer.
  logic                              out_vld_r;
  farp_pkg::res_t                    out_r;
  logic                              skid_vld_r;
  farp_pkg::res_t                    skid_r;

  logic                              in_accept;
  logic                              out_take;
  logic                              res_vld;
  farp_pkg::res_t                    res;
  farp_pkg::tag_info_t               in_info;
  farp_pkg::tag_info_t               pend_info;
  logic [farp_pkg::LenW-1:0]         byte_pos;
  logic [farp_pkg::ValueW-1:0]       byte_ext;
  logic [farp_pkg::SizeW-1:0]        body_dec;

  assign in_stall  = skid_vld_r;
  assign in_accept = in_valid && !skid_vld_r;
  assign out_take  = out_vld_r && !out_stall;

  assign in_info   = farp_pkg::tag_info(in_byte);
  assign pend_info = farp_pkg::tag_info(tag_r);
  assign byte_pos  = pend_info.len - left_r;
  assign byte_ext  = {{(farp_pkg::ValueW-farp_pkg::ByteW){1'b0}}, in_byte};
  assign body_dec  = body_left_r - {{(farp_pkg::SizeW-1){1'b0}}, 1'b1};

  // Next-state and record for the byte on the input port.
  always_comb begin
    phase_nxt      = phase_r;
    tag_nxt        = tag_r;
    left_nxt       = left_r;
    acc_nxt        = acc_r;
    body_class_nxt = body_class_r;
    size_nxt       = size_r;
    body_left_nxt  = body_left_r;
    res_vld        = 1'b0;
    res.kind       = farp_pkg::KIND_NONE;
    res.value      = '0;
    res.done       = 1'b0;
    res.ignored    = 1'b0;
    unique case (phase_r)
      PH_FILE_START: begin
        body_class_nxt = farp_pkg::BODY_DATA;
        size_nxt       = '0;
        body_left_nxt  = '0;
        res_vld        = 1'b1;
        if (in_byte == farp_pkg::TAG_END) begin
          phase_nxt = PH_ENDED;
          res.kind  = farp_pkg::KIND_ARCH_END;
        end else begin
          phase_nxt = PH_NAME;
          res.kind  = farp_pkg::KIND_NAME_BYTE;
          res.value = byte_ext;
        end
      end
      PH_NAME: begin
        res_vld = 1'b1;
        if (in_byte == farp_pkg::TAG_END) begin
          phase_nxt = PH_TAG;
          res.kind  = farp_pkg::KIND_NAME_END;
        end else begin
          res.kind  = farp_pkg::KIND_NAME_BYTE;
          res.value = byte_ext;
        end
      end
      PH_TAG: begin
        if (in_byte == farp_pkg::TAG_END) begin
          res_vld  = 1'b1;
          res.kind = farp_pkg::KIND_ATTR_END;
          if (body_class_r == farp_pkg::BODY_NONE) begin
            phase_nxt   = PH_FILE_START;
            res.done    = 1'b1;
            res.ignored = (size_r != '0);
          end else if (size_r == '0) begin
            phase_nxt = PH_FILE_START;
            res.done  = 1'b1;
          end else begin
            body_left_nxt = size_r;
            phase_nxt     = PH_BODY;
          end
        end else if (in_byte >= farp_pkg::TAG_TYPE_LO && in_byte <= farp_pkg::TAG_TYPE_HI) begin
          body_class_nxt = (in_byte == farp_pkg::TAG_TYPE_LINK) ? farp_pkg::BODY_LINK
                                                                : farp_pkg::BODY_NONE;
          res_vld   = 1'b1;
          res.kind  = farp_pkg::KIND_TYPE;
          res.value = byte_ext;
        end else if (in_info.kind == farp_pkg::KIND_NONE) begin
          phase_nxt = PH_HALTED;
          res_vld   = 1'b1;
          res.kind  = farp_pkg::KIND_BAD_TAG;
          res.value = byte_ext;
        end else begin
          tag_nxt   = in_byte;
          left_nxt  = in_info.len;
          acc_nxt   = '0;
          phase_nxt = PH_FIELD;
        end
      end
      PH_FIELD: begin
        if (pend_info.kind == farp_pkg::KIND_NONE || left_r == '0 ||
            left_r > pend_info.len) begin
          phase_nxt = PH_HALTED;
        end else begin
          if (big_endian_r) begin
            acc_nxt = {acc_r[farp_pkg::ValueW-farp_pkg::ByteW-1:0], in_byte};
          end else begin
            unique case (byte_pos)
              3'd0:    acc_nxt = acc_r | byte_ext;
              3'd1:    acc_nxt = acc_r | (byte_ext << 8);
              3'd2:    acc_nxt = acc_r | (byte_ext << 16);
              3'd3:    acc_nxt = acc_r | (byte_ext << 24);
              default: acc_nxt = acc_r;
            endcase
          end
          left_nxt = left_r - 3'd1;
          if (left_r == 3'd1) begin
            phase_nxt = PH_TAG;
            if (pend_info.kind == farp_pkg::KIND_SIZE) begin
              size_nxt = acc_nxt[farp_pkg::SizeW-1:0];
            end
            res_vld   = 1'b1;
            res.kind  = pend_info.kind;
            res.value = acc_nxt;
          end
        end
      end
      PH_BODY: begin
        body_left_nxt = body_dec;
        res_vld       = 1'b1;
        res.kind      = (body_class_r == farp_pkg::BODY_LINK) ? farp_pkg::KIND_LINK_BYTE
                                                              : farp_pkg::KIND_DATA_BYTE;
        res.value     = byte_ext;
        if (body_dec == '0) begin
          phase_nxt = PH_FILE_START;
          res.done  = 1'b1;
        end
      end
      default: begin
        // Halted or ended: bytes are swallowed without a record.
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FILE_START;
      tag_r        <= '0;
      left_r       <= '0;
      acc_r        <= '0;
      body_class_r <= farp_pkg::BODY_DATA;
      size_r       <= '0;
      body_left_r  <= '0;
      big_endian_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        big_endian_r <= cfg_wr_data;
      end
      if (in_accept) begin
        phase_r      <= phase_nxt;
        tag_r        <= tag_nxt;
        left_r       <= left_nxt;
        acc_r        <= acc_nxt;
        body_class_r <= body_class_nxt;
        size_r       <= size_nxt;
        body_left_r  <= body_left_nxt;
      end
    end
  end

  // Output register with a skid register behind it. A byte is accepted only
  // while the skid register is empty, so a new record always has a place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_take) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_accept && res_vld;
      end
    end else if (in_accept && res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_take) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (in_accept && res_vld) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_record_kind  = out_r.kind;
  assign out_record_value = out_r.value;
  assign out_file_done    = out_r.done;
  assign out_size_ignored = out_r.ignored;

  // A parked record always sits behind a full output register.
  assert property (@(posedge clk) disable iff (!rst_n) skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  // Halted and ended are terminal until reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALTED || phase_r == PH_ENDED) |=> $stable(phase_r))
    else $error("parser left a terminal phase without reset");

  // While a body is running its remaining count is never zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_left_r != '0))
    else $error("body phase with zero bytes left");

  // While a field is being gathered at least one byte is still due.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIELD) |-> (left_r != '0 && left_r <= pend_info.len))
    else $error("field byte count out of range");

  // A record is produced only for an accepted byte or drained from the skid.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r && !skid_vld_r && !in_accept) |=> !out_vld_r)
    else $error("record appeared without an accepted byte");

endmodule
